// File: hdl/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg
// Shared types and constants of the two-level timer wheel: request and result
// payloads, request codes, and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package htw_pkg;

    localparam int WheelBits = 8;
    localparam int WheelSize = 1 << WheelBits;
    localparam int TimerBits = 5;
    localparam int NumTimers = 1 << TimerBits;
    localparam int LinkW     = TimerBits + 1;
    localparam int BktW      = WheelBits + 1;
    localparam int NumBkts   = 2 * WheelSize;
    localparam int RemW      = WheelBits + 2;
    localparam int TickW     = 2 * WheelBits;
    localparam int ReqW      = 3;

    localparam logic [LinkW-1:0] LinkNil = '1;

    localparam logic [ReqW-1:0] REQ_ARM_ONESHOT  = 3'd0;
    localparam logic [ReqW-1:0] REQ_ARM_PERIODIC = 3'd1;
    localparam logic [ReqW-1:0] REQ_CANCEL       = 3'd2;
    localparam logic [ReqW-1:0] REQ_RESET        = 3'd3;
    localparam logic [ReqW-1:0] REQ_UPDATE       = 3'd4;
    localparam logic [ReqW-1:0] REQ_TICK         = 3'd5;
    localparam logic [ReqW-1:0] REQ_ARM_ABS      = 3'd6;
    localparam logic [ReqW-1:0] REQ_NOP          = 3'd7;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_EXPIRE = 1'b1;
    localparam logic STATUS_OK   = 1'b0;

    typedef struct packed {
        logic [ReqW-1:0]      req_type;
        logic [TimerBits-1:0] timer_id;
        logic [TickW-1:0]     delay_ticks;
        logic [TickW-1:0]     expire_at;
    } t_req;

    typedef struct packed {
        logic                 kind;
        logic [TimerBits-1:0] fired_id;
        logic                 status;
        logic [TickW-1:0]     now_ticks;
        logic                 last;
    } t_res;

    typedef struct packed {
        logic latch;
        logic clr_step;
        logic rd_home;
        logic rd_link;
        logic rd_walk;
        logic unl_wr;
        logic lnk_wr;
        logic ld_req_d;
        logic ld_walk_d;
        logic ld_arm;
        logic ld_drop;
        logic set_t_head;
        logic tick_low;
        logic tick_high;
        logic push_exp;
        logic push_ack;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic            clr_done;
        logic [ReqW-1:0] req;
        logic            pend;
        logic            per;
        logic            head_nil;
        logic            rem_zero;
        logic            carry;
        logic            lvl;
        logic            abs_past;
    } t_sts;

endpackage

// File: hdl/htw_dp.sv
// ----------------------------------------------------------------------------
// htw_dp
// Datapath of the timer wheel: cursors, bucket memory, timer table, link
// and unlink arithmetic, and the result holding stage that marks the last one.
// ----------------------------------------------------------------------------
module htw_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  htw_pkg::t_req i_req,
    input  htw_pkg::t_cmd i_cmd,
    output htw_pkg::t_sts o_sts,
    output logic          o_valid,
    output htw_pkg::t_res o_res
);

    localparam int TB = htw_pkg::TimerBits;
    localparam int LW = htw_pkg::LinkW;
    localparam int WB = htw_pkg::WheelBits;
    localparam int BW = htw_pkg::BktW;
    localparam int RW = htw_pkg::RemW;
    localparam int TW = htw_pkg::TickW;
    localparam int NT = htw_pkg::NumTimers;
    localparam int NB = htw_pkg::NumBkts;

    htw_pkg::t_req   r_req;
    logic [TB-1:0]   r_t;
    logic [WB-1:0]   r_low;
    logic [WB-1:0]   r_high;
    logic            r_carry;
    logic            r_lvl;
    logic [TW-1:0]   r_d;
    logic            r_dper;
    logic [BW-1:0]   r_lb;
    logic [RW-1:0]   r_lr;
    logic [BW-1:0]   r_cnt;
    logic [2*LW-1:0] r_rdata;
    logic [2*LW-1:0] r_mem [NB];
    logic [LW-1:0]   r_next [NT];
    logic [LW-1:0]   r_prev [NT];
    logic [BW-1:0]   r_home [NT];
    logic [RW-1:0]   r_rem [NT];
    logic [TW-1:0]   r_period [NT];
    logic [NT-1:0]   r_pend;
    logic [NT-1:0]   r_perf;
    htw_pkg::t_res   r_hold;
    logic            r_hold_v;
    logic            r_valid;
    htw_pkg::t_res   r_res;

    logic [TW-1:0]   now;
    logic [LW-1:0]   cur_prev;
    logic [LW-1:0]   cur_next;
    logic [BW-1:0]   cur_home;
    logic [RW-1:0]   cur_rem;
    logic [LW-1:0]   head;
    logic [LW-1:0]   tail;
    logic [TW-1:0]   dd;
    logic [WB-1:0]   off;
    logic [BW-1:0]   arm_bkt;
    logic [RW-1:0]   arm_rem;
    logic [BW-1:0]   drop_bkt;
    logic [RW-1:0]   drop_rem;
    logic [BW-1:0]   walk_bkt;
    logic [TW-1:0]   req_d;
    logic            req_per;
    logic            mem_we;
    logic [BW-1:0]   mem_wa;
    logic [2*LW-1:0] mem_wd;
    logic            mem_re;
    logic [BW-1:0]   mem_ra;
    logic [LW-1:0]   unl_head;
    logic [LW-1:0]   unl_tail;
    logic [LW-1:0]   lnk_head;
    logic [LW-1:0]   t_link;
    htw_pkg::t_res   new_res;
    htw_pkg::t_res   last_res;

    assign now      = {r_high, r_low};
    assign cur_prev = r_prev[r_t];
    assign cur_next = r_next[r_t];
    assign cur_home = r_home[r_t];
    assign cur_rem  = r_rem[r_t];
    assign head     = r_rdata[2*LW-1:LW];
    assign tail     = r_rdata[LW-1:0];
    assign t_link   = {1'b0, r_t};

    always_comb begin
        dd  = (r_d == '0) ? TW'(1) : r_d;
        off = dd[TW-1:WB];
        if (off != '0) begin
            arm_bkt = {1'b1, r_high + off};
            arm_rem = RW'(dd[WB-1:0]) + RW'(r_low);
        end else begin
            arm_bkt = {1'b0, r_low + dd[WB-1:0]};
            arm_rem = '0;
        end
        if (r_lvl && cur_rem[RW-1:WB] != '0) begin
            drop_bkt = {1'b1, r_high + WB'(cur_rem[RW-1:WB])};
            drop_rem = RW'(cur_rem[WB-1:0]);
        end else begin
            drop_bkt = {1'b0, r_low + cur_rem[WB-1:0]};
            drop_rem = '0;
        end
        walk_bkt = {r_lvl, r_lvl ? r_high : r_low};
    end

    always_comb begin
        case (r_req.req_type)
            htw_pkg::REQ_RESET:   req_d = r_period[r_t];
            htw_pkg::REQ_ARM_ABS: req_d = r_req.expire_at - now;
            default:              req_d = r_req.delay_ticks;
        endcase
        req_per = (r_req.req_type == htw_pkg::REQ_ARM_PERIODIC) ||
                  ((r_req.req_type == htw_pkg::REQ_RESET ||
                    r_req.req_type == htw_pkg::REQ_UPDATE) && r_perf[r_t]);
    end

    always_comb begin
        unl_head = cur_prev[LW-1] ? cur_next : head;
        unl_tail = cur_next[LW-1] ? cur_prev : tail;
        lnk_head = tail[LW-1] ? t_link : head;
        mem_we   = i_cmd.clr_step | i_cmd.unl_wr | i_cmd.lnk_wr;
        if (i_cmd.clr_step) begin
            mem_wa = r_cnt;
            mem_wd = {htw_pkg::LinkNil, htw_pkg::LinkNil};
        end else if (i_cmd.unl_wr) begin
            mem_wa = cur_home;
            mem_wd = {unl_head, unl_tail};
        end else begin
            mem_wa = r_lb;
            mem_wd = {lnk_head, t_link};
        end
        mem_re = i_cmd.rd_home | i_cmd.rd_link | i_cmd.rd_walk;
        if (i_cmd.rd_home) begin
            mem_ra = cur_home;
        end else if (i_cmd.rd_link) begin
            mem_ra = r_lb;
        end else begin
            mem_ra = walk_bkt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low   <= '0;
            r_high  <= '0;
            r_carry <= 1'b0;
            r_lvl   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.tick_low) begin
                r_low   <= r_low + 1'b1;
                r_carry <= (r_low == '1);
                r_lvl   <= 1'b0;
            end
            if (i_cmd.tick_high) begin
                r_high <= r_high + 1'b1;
                r_lvl  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
            r_t   <= i_req.timer_id;
        end
        if (i_cmd.set_t_head) begin
            r_t <= head[TB-1:0];
        end
        if (i_cmd.ld_req_d) begin
            r_d    <= req_d;
            r_dper <= req_per;
        end
        if (i_cmd.ld_walk_d) begin
            r_d    <= r_period[r_t];
            r_dper <= 1'b1;
        end
        if (i_cmd.ld_arm) begin
            r_lb <= arm_bkt;
            r_lr <= arm_rem;
        end
        if (i_cmd.ld_drop) begin
            r_lb <= drop_bkt;
            r_lr <= drop_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_perf <= '0;
            for (int i = 0; i < NT; i++) begin
                r_period[i] <= '0;
            end
        end else begin
            if (i_cmd.ld_arm) begin
                r_period[r_t] <= dd;
                r_perf[r_t]   <= r_dper;
            end
            if (i_cmd.unl_wr) begin
                r_pend[r_t] <= 1'b0;
            end
            if (i_cmd.lnk_wr) begin
                r_pend[r_t] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.unl_wr) begin
            if (!cur_prev[LW-1]) begin
                r_next[cur_prev[TB-1:0]] <= cur_next;
            end
            if (!cur_next[LW-1]) begin
                r_prev[cur_next[TB-1:0]] <= cur_prev;
            end
        end
        if (i_cmd.lnk_wr) begin
            r_prev[r_t] <= tail;
            r_next[r_t] <= htw_pkg::LinkNil;
            if (!tail[LW-1]) begin
                r_next[tail[TB-1:0]] <= t_link;
            end
            r_home[r_t] <= r_lb;
            r_rem[r_t]  <= r_lr;
        end
    end

    always_comb begin
        new_res.kind      = i_cmd.push_exp ? htw_pkg::KIND_EXPIRE : htw_pkg::KIND_ACK;
        new_res.fired_id  = r_t;
        new_res.status    = htw_pkg::STATUS_OK;
        new_res.now_ticks = now;
        new_res.last      = 1'b0;
        last_res          = r_hold;
        last_res.last     = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_hold_v <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cmd.push_exp || i_cmd.push_ack) begin
                if (r_hold_v) begin
                    r_valid <= 1'b1;
                    r_res   <= r_hold;
                end
                r_hold   <= new_res;
                r_hold_v <= 1'b1;
            end else if (i_cmd.flush) begin
                if (r_hold_v) begin
                    r_valid <= 1'b1;
                    r_res   <= last_res;
                end
                r_hold_v <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        o_sts.clr_done = (r_cnt == BW'(NB - 1));
        o_sts.req      = r_req.req_type;
        o_sts.pend     = r_pend[r_t];
        o_sts.per      = r_perf[r_t];
        o_sts.head_nil = head[LW-1];
        o_sts.rem_zero = (cur_rem == '0);
        o_sts.carry    = r_carry;
        o_sts.lvl      = r_lvl;
        o_sts.abs_past = (r_req.expire_at <= now);
    end

`ifndef SYNTHESIS
    a_push_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((i_cmd.push_exp || i_cmd.push_ack) && i_cmd.flush))
        else $error("push and flush together");
    a_link_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.lnk_wr |-> !r_pend[r_t])
        else $error("link of a pending timer");
    a_unlink_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.unl_wr |-> r_pend[r_t])
        else $error("unlink of an idle timer");
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> !r_hold_v)
        else $error("hold stage not drained");
`endif

endmodule

// File: hdl/htw_ctrl.sv
// ----------------------------------------------------------------------------
// htw_ctrl
// Sequencer of the timer wheel: clears the bucket memory after reset, then
// steps each request through unlink, link, bucket walk and result delivery.
// ----------------------------------------------------------------------------
module htw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  htw_pkg::t_sts i_sts,
    output htw_pkg::t_cmd o_cmd
);

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DISP   = 4'd2;
    localparam logic [3:0] S_ARM    = 4'd3;
    localparam logic [3:0] S_UNL_RD = 4'd4;
    localparam logic [3:0] S_UNL_WR = 4'd5;
    localparam logic [3:0] S_LNK_RD = 4'd6;
    localparam logic [3:0] S_LNK_WR = 4'd7;
    localparam logic [3:0] S_WRD    = 4'd8;
    localparam logic [3:0] S_WCHK   = 4'd9;
    localparam logic [3:0] S_WDEC   = 4'd10;
    localparam logic [3:0] S_ACK    = 4'd11;
    localparam logic [3:0] S_FLUSH  = 4'd12;

    localparam logic [1:0] RET_ARM    = 2'd0;
    localparam logic [1:0] RET_CANCEL = 2'd1;
    localparam logic [1:0] RET_WALK   = 2'd2;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [1:0] r_ret;
    logic [1:0] n_ret;
    logic       r_lnk_walk;
    logic       n_lnk_walk;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        n_ret      = r_ret;
        n_lnk_walk = r_lnk_walk;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.req)
                    htw_pkg::REQ_NOP: begin
                        n_state = S_IDLE;
                    end
                    htw_pkg::REQ_TICK: begin
                        o_cmd.tick_low = 1'b1;
                        n_state        = S_WRD;
                    end
                    htw_pkg::REQ_CANCEL: begin
                        if (i_sts.pend) begin
                            n_ret   = RET_CANCEL;
                            n_state = S_UNL_RD;
                        end else begin
                            n_state = S_ACK;
                        end
                    end
                    htw_pkg::REQ_ARM_ABS: begin
                        if (i_sts.abs_past) begin
                            o_cmd.push_exp = 1'b1;
                            n_state        = S_ACK;
                        end else begin
                            o_cmd.ld_req_d = 1'b1;
                            n_lnk_walk     = 1'b0;
                            n_state        = S_ARM;
                        end
                    end
                    default: begin
                        o_cmd.ld_req_d = 1'b1;
                        n_lnk_walk     = 1'b0;
                        n_state        = S_ARM;
                    end
                endcase
            end
            S_ARM: begin
                o_cmd.ld_arm = 1'b1;
                if (i_sts.pend) begin
                    n_ret   = RET_ARM;
                    n_state = S_UNL_RD;
                end else begin
                    n_state = S_LNK_RD;
                end
            end
            S_UNL_RD: begin
                o_cmd.rd_home = 1'b1;
                n_state       = S_UNL_WR;
            end
            S_UNL_WR: begin
                o_cmd.unl_wr = 1'b1;
                case (r_ret)
                    RET_ARM:    n_state = S_LNK_RD;
                    RET_CANCEL: n_state = S_ACK;
                    default:    n_state = S_WDEC;
                endcase
            end
            S_LNK_RD: begin
                o_cmd.rd_link = 1'b1;
                n_state       = S_LNK_WR;
            end
            S_LNK_WR: begin
                o_cmd.lnk_wr = 1'b1;
                n_state      = r_lnk_walk ? S_WRD : S_ACK;
            end
            S_WRD: begin
                o_cmd.rd_walk = 1'b1;
                n_state       = S_WCHK;
            end
            S_WCHK: begin
                if (i_sts.head_nil) begin
                    if (!i_sts.lvl && i_sts.carry) begin
                        o_cmd.tick_high = 1'b1;
                        n_state         = S_WRD;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end else begin
                    o_cmd.set_t_head = 1'b1;
                    n_ret            = RET_WALK;
                    n_state          = S_UNL_WR;
                end
            end
            S_WDEC: begin
                n_lnk_walk = 1'b1;
                if (i_sts.rem_zero) begin
                    o_cmd.push_exp = 1'b1;
                    if (i_sts.per) begin
                        o_cmd.ld_walk_d = 1'b1;
                        n_state         = S_ARM;
                    end else begin
                        n_state = S_WRD;
                    end
                end else begin
                    o_cmd.ld_drop = 1'b1;
                    n_state       = S_LNK_RD;
                end
            end
            S_ACK: begin
                o_cmd.push_ack = 1'b1;
                n_state        = S_FLUSH;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_ret      <= RET_ARM;
            r_lnk_walk <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_lnk_walk <= n_lnk_walk;
        end
    end

    assign busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_accept_disp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && start) |=> (r_state == S_DISP))
        else $error("accepted request not dispatched");
    a_walk_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WCHK && !i_sts.head_nil) |=> (r_state == S_UNL_WR && r_ret == RET_WALK))
        else $error("walk unlink lost its return");
    a_flush_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) |=> !busy)
        else $error("flush did not end the request");
`endif

endmodule

// File: hdl/hierarchical_timer_wheel.sv
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel
// Two-level hashed timing wheel over a table of timers: arm, cancel, reset,
// update, absolute arm and tick requests, with expiry events and acks.
//
// channel   ports                         handshake
// request   i_req (t_req)                 start high while busy low
// result    o_res (t_res)                 o_valid strobe, one cycle, no stall
//
// After reset busy stays high while the bucket memory clears. Arm-type
// requests unlink a pending timer, then link it and ack; cancel unlinks a
// pending timer and acks; an absolute arm already due expires and acks; a
// no-op returns to idle. A tick walks the low bucket at the new time, and
// the high bucket on a level wrap. A result leaves in the cycle after the
// next one is produced or the request ends; the receiver cannot stall.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  htw_pkg::t_req i_req,
    output logic          o_valid,
    output htw_pkg::t_res o_res
);

    htw_pkg::t_cmd cmd;
    htw_pkg::t_sts sts;

    htw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    htw_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule
